FILE: src/dngs_pkg.sv
// Shared types and constants for the softened gravity summation engine.
package dngs_pkg;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    localparam logic [1:0] CFG_SOFTENING  = 2'd0;
    localparam logic [1:0] CFG_BODY_COUNT = 2'd1;

    // 1.0 in Q8.24 squared, in Q16.32
    localparam logic [47:0] SOFT2_RESET = 48'h0001_0000_0000;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic        [31:0] mass;
        logic               responds;
    } t_particle;

    typedef struct packed {
        logic [10:0] body_count;
        logic [47:0] soft2;
    } t_cfg;

    typedef struct packed {
        logic        start;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] den;
    } t_div_req;

endpackage

FILE: src/dngs_ram.sv
// Generic single-port-write, registered-read RAM.
module dngs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: src/dngs_front.sv
// Front end: request intake, configuration registers, particle writes, evaluate queue.
module dngs_front #(
    parameter int MAX_BODIES = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          i_op,
    input  logic [9:0]                    i_index,
    input  logic signed [31:0]            i_pos_x,
    input  logic signed [31:0]            i_pos_y,
    input  logic signed [31:0]            i_pos_z,
    input  logic [31:0]                   i_particle_mass,
    input  logic                          i_responds,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    output dngs_pkg::t_cfg                o_cfg,
    output logic                          o_we,
    output logic [$clog2(MAX_BODIES)-1:0] o_waddr,
    output dngs_pkg::t_particle           o_wdata,
    output logic                          o_q_valid,
    output logic [9:0]                    o_q_idx,
    input  logic                          i_q_pop,
    input  logic                          i_busy
);
    localparam int AW = $clog2(MAX_BODIES);

    logic [47:0] r_soft2;
    logic [10:0] r_count;
    logic [63:0] soft_sq;
    logic [9:0]  r_q [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;
    logic        accept;
    logic        push_eval;
    logic [AW+9:0] idx_ext;
    logic        in_range;

    assign soft_sq = {32'b0, i_cfg_data} * {32'b0, i_cfg_data};
    assign o_cfg_ready = 1'b1;
    assign o_cfg = '{body_count: r_count, soft2: r_soft2};

    // loads wait until every earlier evaluate has finished and written its result
    assign full = (r_cnt == 2'd2) ||
                  ((i_op == dngs_pkg::OP_LOAD) && ((r_cnt != 2'd0) || i_busy));
    assign accept    = push && !full;
    assign push_eval = accept && (i_op == dngs_pkg::OP_EVAL);

    assign idx_ext  = {{AW{1'b0}}, i_index};
    assign in_range = idx_ext < (AW+10)'(MAX_BODIES);
    assign o_we     = accept && (i_op == dngs_pkg::OP_LOAD) && in_range;
    assign o_waddr  = idx_ext[AW-1:0];
    assign o_wdata  = '{pos_x: i_pos_x, pos_y: i_pos_y, pos_z: i_pos_z,
                        mass: i_particle_mass, responds: i_responds};

    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_idx   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_soft2 <= dngs_pkg::SOFT2_RESET;
            r_count <= '0;
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_cnt   <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    dngs_pkg::CFG_SOFTENING:  r_soft2 <= soft_sq[63:16];
                    dngs_pkg::CFG_BODY_COUNT: r_count <= i_cfg_data[10:0];
                    default: ;
                endcase
            end
            if (push_eval) begin
                r_wp <= !r_wp;
            end
            if (i_q_pop && o_q_valid) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(push_eval) - 2'(i_q_pop && o_q_valid);
        end
        if (push_eval) begin
            r_q[r_wp] <= i_index;
        end
    end
endmodule

FILE: src/dngs_sqrt.sv
// Bit-serial integer square root of a 64-bit value, one result bit per cycle.
module dngs_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_value,
    output logic        o_done,
    output logic [31:0] o_root
);
    logic [63:0] r_v;
    logic [63:0] r_r;
    logic [63:0] r_bit;
    logic        r_busy;
    logic [63:0] trial;

    assign trial  = r_r + r_bit;
    assign o_root = r_r[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_v    <= i_value;
                r_r    <= '0;
                r_bit  <= 64'h4000_0000_0000_0000;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_v >= trial) begin
                    r_v <= r_v - trial;
                    r_r <= (r_r >> 1) + r_bit;
                end else begin
                    r_r <= r_r >> 1;
                end
                r_bit <= r_bit >> 2;
                if (r_bit[0]) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule

FILE: src/dngs_div.sv
// Restoring divider: floor({hi,lo} / den), held at all ones when the quotient overflows.
module dngs_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dngs_pkg::t_div_req i_req,
    output logic               o_done,
    output logic [63:0]        o_quot
);
    logic [63:0] r_rem;
    logic [63:0] r_lo;
    logic [63:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [63:0] shifted;
    logic        take;

    assign shifted = {r_rem[62:0], r_lo[63]};
    assign take    = r_rem[63] || (shifted >= r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_req.start) begin
                r_rem <= i_req.hi;
                r_lo  <= i_req.lo;
                r_den <= i_req.den;
                r_cnt <= '0;
                if (i_req.hi >= i_req.den) begin
                    o_quot <= '1;
                    o_done <= 1'b1;
                end else begin
                    o_quot <= '0;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem  <= take ? shifted - r_den : shifted;
                r_lo   <= {r_lo[62:0], 1'b0};
                o_quot <= {o_quot[62:0], take};
                r_cnt  <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule

FILE: src/dngs_back.sv
// Back end: walks the source bodies for one evaluate request and holds the result.
module dngs_back #(
    parameter int MAX_BODIES = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dngs_pkg::t_cfg                i_cfg,
    input  logic                          i_q_valid,
    input  logic [9:0]                    i_q_idx,
    output logic                          o_q_pop,
    output logic                          o_busy,
    output logic [$clog2(MAX_BODIES)-1:0] o_raddr,
    input  dngs_pkg::t_particle           i_rdata,
    output logic                          empty,
    input  logic                          pop,
    output logic [9:0]                    o_result_index,
    output logic signed [47:0]            o_acc_x,
    output logic signed [47:0]            o_acc_y,
    output logic signed [47:0]            o_acc_z,
    output logic signed [47:0]            o_potential,
    output logic                          o_saturated
);
    localparam int AW = $clog2(MAX_BODIES);
    localparam int CW = $clog2(MAX_BODIES + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_RDI, S_NEXT, S_LDJ, S_SQ, S_SQRT_GO, S_SQRT_W, S_RR2,
        S_POT_GO, S_POT_W, S_MUL, S_DIV1_GO, S_DIV1_W, S_DIV2_GO, S_DIV2_W, S_OUT
    } t_state;

    t_state             r_state;
    logic [9:0]         r_idx;
    dngs_pkg::t_particle r_pi;
    logic [CW-1:0]      r_j;
    logic [31:0]        r_dabs [3];
    logic               r_dneg [3];
    logic [31:0]        r_m;
    logic [49:0]        r_r2;
    logic [1:0]         r_ax;
    logic [31:0]        r_rr;
    logic [63:0]        r_rr2;
    logic [63:0]        r_prod;
    logic [63:0]        r_q1;
    logic signed [47:0] r_acc [3];
    logic signed [47:0] r_pot;
    logic               r_sat;
    logic               r_res_valid;

    logic [CW-1:0]      count_eff;
    logic [AW+9:0]      qidx_ext;
    logic [63:0]        sq_ax;
    logic [49:0]        r2_next;
    logic               sqrt_done;
    logic [31:0]        sqrt_root;
    dngs_pkg::t_div_req div_req;
    logic               div_done;
    logic [63:0]        div_quot;
    logic [48:0]        acc_upd;
    logic [48:0]        pot_upd;
    logic signed [32:0] d_x;
    logic signed [32:0] d_y;
    logic signed [32:0] d_z;

    // add one clipped term to a running sum: {saturated, sum}
    function automatic logic [48:0] f_add(input logic signed [47:0] acc,
                                          input logic [63:0] mag, input logic neg);
        logic               sat;
        logic [47:0]        t;
        logic signed [49:0] a50;
        logic signed [49:0] t50;
        logic signed [49:0] s;
        sat = mag > 64'h0000_7FFF_FFFF_FFFF;
        t   = sat ? 48'h7FFF_FFFF_FFFF : mag[47:0];
        a50 = 50'(acc);
        t50 = $signed({2'b00, t});
        s   = neg ? a50 - t50 : a50 + t50;
        if (s > $signed(50'h0_7FFF_FFFF_FFFF)) begin
            sat = 1'b1;
            s   = $signed(50'h0_7FFF_FFFF_FFFF);
        end else if (s < $signed(50'h3_8000_0000_0000)) begin
            sat = 1'b1;
            s   = $signed(50'h3_8000_0000_0000);
        end
        return {sat, s[47:0]};
    endfunction

    assign count_eff = (32'(i_cfg.body_count) > 32'(MAX_BODIES)) ?
                       CW'(MAX_BODIES) : CW'(i_cfg.body_count);
    assign qidx_ext  = {{AW{1'b0}}, i_q_idx};
    assign o_raddr   = (r_state == S_IDLE) ? qidx_ext[AW-1:0] : r_j[AW-1:0];
    assign o_q_pop   = (r_state == S_IDLE) && i_q_valid;
    assign o_busy    = (r_state != S_IDLE);
    assign empty     = !r_res_valid;

    assign sq_ax   = {32'b0, r_dabs[r_ax]} * {32'b0, r_dabs[r_ax]};
    assign r2_next = r_r2 + 50'(sq_ax[63:16]);
    assign acc_upd = f_add(r_acc[r_ax], div_quot, !r_dneg[r_ax] && (r_dabs[r_ax] != '0));
    assign pot_upd = f_add(r_pot, div_quot, 1'b1);

    assign d_x = 33'(r_pi.pos_x) - 33'(i_rdata.pos_x);
    assign d_y = 33'(r_pi.pos_y) - 33'(i_rdata.pos_y);
    assign d_z = 33'(r_pi.pos_z) - 33'(i_rdata.pos_z);

    always_comb begin
        div_req = '0;
        case (r_state)
            S_POT_GO: begin
                div_req.start = 1'b1;
                div_req.lo    = {1'b0, r_m, 31'b0};
                div_req.den   = {32'b0, r_rr};
            end
            S_DIV1_GO: begin
                div_req.start = 1'b1;
                div_req.hi    = {23'b0, r_prod[63:23]} >> 18;
                div_req.lo    = {r_prod[40:0], 23'b0};
                div_req.den   = {32'b0, r_rr};
            end
            S_DIV2_GO: begin
                div_req.start = 1'b1;
                div_req.hi    = {30'b0, r_q1[63:30]} >> 4;
                div_req.lo    = {r_q1[33:0], 30'b0};
                div_req.den   = r_rr2;
            end
            default: ;
        endcase
    end

    dngs_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_SQRT_GO),
        .i_value ({r_r2, 14'b0}),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    dngs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            if (pop && r_res_valid) begin
                r_res_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_idx     <= i_q_idx;
                        r_acc[0]  <= '0;
                        r_acc[1]  <= '0;
                        r_acc[2]  <= '0;
                        r_pot     <= '0;
                        r_sat     <= 1'b0;
                        r_j       <= '0;
                        r_state   <= S_RDI;
                    end
                end
                S_RDI: begin
                    r_pi <= i_rdata;
                    if ((32'(r_idx) < 32'(count_eff)) && i_rdata.responds) begin
                        r_state <= S_NEXT;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_NEXT: begin
                    if (r_j == count_eff) begin
                        r_state <= S_OUT;
                    end else if (32'(r_j) == 32'(r_idx)) begin
                        r_j <= r_j + CW'(1);
                    end else begin
                        r_state <= S_LDJ;
                    end
                end
                S_LDJ: begin
                    r_dabs[0] <= d_x[32] ? 32'(-d_x) : d_x[31:0];
                    r_dabs[1] <= d_y[32] ? 32'(-d_y) : d_y[31:0];
                    r_dabs[2] <= d_z[32] ? 32'(-d_z) : d_z[31:0];
                    r_dneg[0] <= d_x[32];
                    r_dneg[1] <= d_y[32];
                    r_dneg[2] <= d_z[32];
                    r_m       <= i_rdata.mass;
                    r_r2      <= 50'(i_cfg.soft2);
                    r_ax      <= '0;
                    r_state   <= S_SQ;
                end
                S_SQ: begin
                    if (r_ax == 2'd2) begin
                        // force one LSB when the softened squared distance rounds to zero
                        r_r2    <= (r2_next == '0) ? 50'd1 : r2_next;
                        r_state <= S_SQRT_GO;
                    end else begin
                        r_r2 <= r2_next;
                        r_ax <= r_ax + 2'd1;
                    end
                end
                S_SQRT_GO: r_state <= S_SQRT_W;
                S_SQRT_W: begin
                    if (sqrt_done) begin
                        r_rr    <= sqrt_root;
                        r_state <= S_RR2;
                    end
                end
                S_RR2: begin
                    r_rr2   <= {32'b0, r_rr} * {32'b0, r_rr};
                    r_state <= S_POT_GO;
                end
                S_POT_GO: r_state <= S_POT_W;
                S_POT_W: begin
                    if (div_done) begin
                        r_pot   <= pot_upd[47:0];
                        r_sat   <= r_sat | pot_upd[48];
                        r_ax    <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= {32'b0, r_dabs[r_ax]} * {32'b0, r_m};
                    r_state <= S_DIV1_GO;
                end
                S_DIV1_GO: r_state <= S_DIV1_W;
                S_DIV1_W: begin
                    if (div_done) begin
                        r_q1    <= div_quot;
                        r_state <= S_DIV2_GO;
                    end
                end
                S_DIV2_GO: r_state <= S_DIV2_W;
                S_DIV2_W: begin
                    if (div_done) begin
                        r_acc[r_ax] <= acc_upd[47:0];
                        r_sat       <= r_sat | acc_upd[48];
                        if (r_ax == 2'd2) begin
                            r_j     <= r_j + CW'(1);
                            r_state <= S_NEXT;
                        end else begin
                            r_ax    <= r_ax + 2'd1;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_res_valid) begin
                        o_result_index <= r_idx;
                        o_acc_x        <= r_acc[0];
                        o_acc_y        <= r_acc[1];
                        o_acc_z        <= r_acc[2];
                        o_potential    <= r_pot;
                        o_saturated    <= r_sat;
                        r_res_valid    <= 1'b1;
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: src/direct_nbody_gravity_sum.sv
// Top level of the direct-summation softened gravity engine.
//
//   channel   direction  handshake                      carries
//   request   in         push / full                    op, index, position, mass, responds
//   result    out        empty / pop                    index, acceleration, potential, flag
//   config    in         i_cfg_valid / o_cfg_ready      register index, data
//
// A load is written into the store when it is accepted; it waits while any evaluate is queued or running.
// An in-range, responding evaluate walks every source other than itself, around a queue read,
// index read, self skip, final check and result write; the work per source is set by seven
// quotients of the bit-serial divider and the square root.
// Out-of-range or non-responding evaluates go from the index read straight to the result write.
// Reset is synchronous; the particle store is not cleared. A waiting result
// does not block the next evaluate until it must be written out.
module direct_nbody_gravity_sum #(
    parameter int MAX_BODIES = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic               i_op,
    input  logic [9:0]         i_index,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic [31:0]        i_particle_mass,
    input  logic               i_responds,
    output logic               empty,
    input  logic               pop,
    output logic [9:0]         o_result_index,
    output logic signed [47:0] o_acc_x,
    output logic signed [47:0] o_acc_y,
    output logic signed [47:0] o_acc_z,
    output logic signed [47:0] o_potential,
    output logic               o_saturated,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    localparam int AW = $clog2(MAX_BODIES);

    dngs_pkg::t_cfg      cfg;
    logic                we;
    logic [AW-1:0]       waddr;
    dngs_pkg::t_particle wdata;
    logic [AW-1:0]       raddr;
    dngs_pkg::t_particle rdata;
    logic                q_valid;
    logic [9:0]          q_idx;
    logic                q_pop;
    logic                busy;

    dngs_front #(.MAX_BODIES(MAX_BODIES)) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_op            (i_op),
        .i_index         (i_index),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_pos_z         (i_pos_z),
        .i_particle_mass (i_particle_mass),
        .i_responds      (i_responds),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_cfg           (cfg),
        .o_we            (we),
        .o_waddr         (waddr),
        .o_wdata         (wdata),
        .o_q_valid       (q_valid),
        .o_q_idx         (q_idx),
        .i_q_pop         (q_pop),
        .i_busy          (busy)
    );

    dngs_ram #(.WIDTH($bits(dngs_pkg::t_particle)), .DEPTH(MAX_BODIES)) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    dngs_back #(.MAX_BODIES(MAX_BODIES)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_q_valid      (q_valid),
        .i_q_idx        (q_idx),
        .o_q_pop        (q_pop),
        .o_busy         (busy),
        .o_raddr        (raddr),
        .i_rdata        (rdata),
        .empty          (empty),
        .pop            (pop),
        .o_result_index (o_result_index),
        .o_acc_x        (o_acc_x),
        .o_acc_y        (o_acc_y),
        .o_acc_z        (o_acc_z),
        .o_potential    (o_potential),
        .o_saturated    (o_saturated)
    );
endmodule

FILE: src/dngs_chk.sv
// Port-level checks for the gravity engine, bound to the top level.
module dngs_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input logic [9:0]         o_result_index,
    input logic signed [47:0] o_acc_x,
    input logic signed [47:0] o_potential
);
    a_empty_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_ready_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("request side full after reset");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_acc_x) && $stable(o_result_index))
        else $error("waiting result changed");

    a_potential_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_potential[47] || (o_potential == '0)))
        else $error("positive potential");
endmodule

bind direct_nbody_gravity_sum dngs_chk u_chk (.*);

FILE: test/direct_nbody_gravity_sum_tb.sv
// Testbench for the softened gravity summation engine: directed table, then random phases.
`timescale 1ns / 1ps

module direct_nbody_gravity_sum_tb;

    localparam int SLOTS = 1024;
    localparam logic [63:0] TERM_MAX = 64'h0000_7FFF_FFFF_FFFF;
    localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SUM_LO = -64'sh0000_8000_0000_0000;
    localparam logic [31:0] ONE_Q824 = 32'h0100_0000;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic        op;
        logic [9:0]  index;
        logic [31:0] px, py, pz, mass;
        logic        resp;
        logic        known_zero;
        logic [1:0]  reg_index;
        logic [31:0] reg_data;
    } t_row;

    typedef struct {
        logic [9:0]  index;
        logic [47:0] ax, ay, az, pot;
        logic        sat;
    } t_field_sums;

    logic               i_clk;
    logic               i_rst_n;
    logic               push;
    logic               full;
    logic               i_op;
    logic [9:0]         i_index;
    logic signed [31:0] i_pos_x, i_pos_y, i_pos_z;
    logic [31:0]        i_particle_mass;
    logic               i_responds;
    logic               empty;
    logic               pop;
    logic [9:0]         o_result_index;
    logic signed [47:0] o_acc_x, o_acc_y, o_acc_z, o_potential;
    logic               o_saturated;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;

    direct_nbody_gravity_sum dut (.*);

    // particle store mirror and register copies
    logic signed [31:0] pos_x_mem [SLOTS];
    logic signed [31:0] pos_y_mem [SLOTS];
    logic signed [31:0] pos_z_mem [SLOTS];
    logic [31:0]        mass_mem [SLOTS];
    logic               resp_mem [SLOTS];
    logic               loaded [SLOTS];
    logic [63:0]        soft_sq;
    logic [10:0]        bodies;

    t_field_sums expected_sums[$];
    t_row        rows[$];
    int errors = 0;
    int n_loads = 0;
    int n_evals = 0;
    int n_checked = 0;
    int n_sat = 0;
    bit quiet = 0;

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #200ms;
        $display("direct_nbody_gravity_sum_tb: FAIL");
        $finish;
    end

    function automatic logic [63:0] isqrt(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // floor(a*b/c), held at all ones on overflow
    function automatic logic [63:0] scaled_quot(logic [63:0] a, logic [63:0] b,
                                                logic [63:0] c);
        logic [127:0] p, q;
        p = {64'd0, a} * {64'd0, b};
        q = p / {64'd0, c};
        return (q[127:64] != 0) ? '1 : q[63:0];
    endfunction

    function automatic logic [63:0] clip_mag(logic [63:0] t, inout logic sat);
        if (t > TERM_MAX) begin
            sat = 1;
            return TERM_MAX;
        end
        return t;
    endfunction

    function automatic longint add_clip(longint a, longint t, inout logic sat);
        longint s;
        s = a + t;
        if (s > SUM_HI) begin
            sat = 1;
            return SUM_HI;
        end
        if (s < SUM_LO) begin
            sat = 1;
            return SUM_LO;
        end
        return s;
    endfunction

    function automatic longint accel_part(logic [63:0] m, longint d, logic [63:0] rr,
                                          inout logic sat);
        logic [63:0] ad, q1, t;
        ad = (d < 0) ? -d : d;
        q1 = scaled_quot(m * ad, 64'd1 << 23, rr);
        t = clip_mag(scaled_quot(q1, 64'd1 << 30, rr * rr), sat);
        return (d > 0) ? -$signed(t) : $signed(t);
    endfunction

    function automatic t_field_sums gravity_at(logic [9:0] idx);
        t_field_sums res;
        int count;
        longint ax, ay, az, pot, dx, dy, dz;
        logic [63:0] adx, ady, adz, r2, rr, m;
        logic sat;
        count = (bodies > SLOTS) ? SLOTS : bodies;
        ax = 0; ay = 0; az = 0; pot = 0; sat = 0;
        if (idx < count && resp_mem[idx]) begin
            for (int j = 0; j < count; j++) begin
                if (j == idx) continue;
                dx = longint'(pos_x_mem[idx]) - longint'(pos_x_mem[j]);
                dy = longint'(pos_y_mem[idx]) - longint'(pos_y_mem[j]);
                dz = longint'(pos_z_mem[idx]) - longint'(pos_z_mem[j]);
                adx = (dx < 0) ? -dx : dx;
                ady = (dy < 0) ? -dy : dy;
                adz = (dz < 0) ? -dz : dz;
                m = {32'd0, mass_mem[j]};
                r2 = ((adx * adx) >> 16) + ((ady * ady) >> 16) + ((adz * adz) >> 16)
                   + soft_sq;
                if (r2 == 0) r2 = 1;
                rr = isqrt(r2 << 14);
                ax = add_clip(ax, accel_part(m, dx, rr, sat), sat);
                ay = add_clip(ay, accel_part(m, dy, rr, sat), sat);
                az = add_clip(az, accel_part(m, dz, rr, sat), sat);
                pot = add_clip(pot,
                    -$signed(clip_mag(scaled_quot(m, 64'd1 << 31, rr), sat)), sat);
            end
        end
        res.index = idx;
        res.ax = ax[47:0];
        res.ay = ay[47:0];
        res.az = az[47:0];
        res.pot = pot[47:0];
        res.sat = sat;
        return res;
    endfunction

    function automatic bit sources_loaded(int count);
        for (int j = 0; j < count && j < SLOTS; j++)
            if (!loaded[j]) return 0;
        return 1;
    endfunction

    function automatic void check_field(string name, logic [47:0] exp_v,
                                        logic [47:0] act_v);
        if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v,
                     act_v);
        end
    endfunction

    // result side: compare every popped result, stall in random bursts
    initial begin
        int stall;
        t_field_sums e;
        stall = 0;
        pop <= 0;
        forever begin
            @(posedge i_clk);
            if (!empty && pop) begin
                if (expected_sums.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual index %0d",
                             $time, o_result_index);
                end else begin
                    e = expected_sums.pop_front();
                    check_field("index", 48'(e.index), 48'(o_result_index));
                    check_field("acc_x", e.ax, o_acc_x);
                    check_field("acc_y", e.ay, o_acc_y);
                    check_field("acc_z", e.az, o_acc_z);
                    check_field("potential", e.pot, o_potential);
                    check_field("saturated", 48'(e.sat), 48'(o_saturated));
                    n_checked++;
                    if (e.sat) n_sat++;
                end
            end
            if (stall > 0) begin
                pop <= 0;
                stall--;
            end else begin
                pop <= 1;
                if (!quiet && $urandom_range(0, 11) == 0) stall = $urandom_range(1, 16);
            end
        end
    end

    task automatic sender_gap();
        if (!quiet && $urandom_range(0, 5) == 0) begin
            push <= 0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    task automatic send_request(logic op, logic [9:0] idx, logic [31:0] px,
                                logic [31:0] py, logic [31:0] pz, logic [31:0] m,
                                logic resp, logic known_zero);
        t_field_sums z;
        sender_gap();
        push <= 1;
        i_op <= op;
        i_index <= idx;
        i_pos_x <= px;
        i_pos_y <= py;
        i_pos_z <= pz;
        i_particle_mass <= m;
        i_responds <= resp;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        if (op == dngs_pkg::OP_LOAD) begin
            pos_x_mem[idx] = px;
            pos_y_mem[idx] = py;
            pos_z_mem[idx] = pz;
            mass_mem[idx] = m;
            resp_mem[idx] = resp;
            loaded[idx] = 1;
            n_loads++;
        end else begin
            n_evals++;
            if (known_zero) begin
                z = '{index: idx, ax: '0, ay: '0, az: '0, pot: '0, sat: 0};
                expected_sums.push_back(z);
            end else begin
                expected_sums.push_back(gravity_at(idx));
            end
        end
    endtask

    task automatic drain();
        push <= 0;
        while (expected_sums.size() != 0) @(posedge i_clk);
        // a trailing load may still be in flight
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        drain();
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 0;
        if (idx == dngs_pkg::CFG_SOFTENING) begin
            soft_sq = ({32'd0, data} * {32'd0, data}) >> 16;
        end else if (idx == dngs_pkg::CFG_BODY_COUNT) begin
            bodies = data[10:0];
        end
    endtask

    function automatic void add_item(logic op, logic [9:0] idx, logic [31:0] px,
                                     logic [31:0] py, logic [31:0] pz, logic [31:0] m,
                                     logic resp, logic known_zero);
        t_row r;
        r = '{kind: ROW_ITEM, op: op, index: idx, px: px, py: py, pz: pz, mass: m,
              resp: resp, known_zero: known_zero, reg_index: '0, reg_data: '0};
        rows.push_back(r);
    endfunction

    function automatic void add_reg(logic [1:0] idx, logic [31:0] data);
        t_row r;
        r = '{kind: ROW_CFG, op: dngs_pkg::OP_LOAD, index: '0, px: '0, py: '0, pz: '0,
              mass: '0, resp: 0, known_zero: 0, reg_index: idx, reg_data: data};
        rows.push_back(r);
    endfunction

    function automatic logic [31:0] rand_coord();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 5))
            0: return r;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            default: return {{6{r[25]}}, r[25:0]};
        endcase
    endfunction

    function automatic logic [31:0] rand_mass();
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: return '1;
            2: return '0;
            default: return $urandom_range(0, 32'h0FFF_FFFF);
        endcase
    endfunction

    initial begin
        int done;
        int phase_len;
        int count;
        int slot;
        logic [31:0] soft_len;
        logic [9:0] idx;
        bit paused;

        i_rst_n <= 0;
        push <= 0;
        i_op <= dngs_pkg::OP_LOAD;
        i_index <= '0;
        i_pos_x <= '0;
        i_pos_y <= '0;
        i_pos_z <= '0;
        i_particle_mass <= '0;
        i_responds <= 0;
        i_cfg_valid <= 0;
        i_cfg_index <= dngs_pkg::CFG_SOFTENING;
        i_cfg_data <= '0;
        for (int k = 0; k < SLOTS; k++) loaded[k] = 0;
        soft_sq = 64'(dngs_pkg::SOFT2_RESET);
        bodies = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // no sources after reset, then a count of four with extreme positions and masses
        add_item(dngs_pkg::OP_EVAL, 10'd0, 0, 0, 0, 0, 0, 1);
        add_item(dngs_pkg::OP_EVAL, 10'd1023, 0, 0, 0, 0, 0, 1);
        add_item(dngs_pkg::OP_LOAD, 10'd0, 0, 0, 0, ONE_Q824, 1, 0);
        add_item(dngs_pkg::OP_LOAD, 10'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 '1, 1, 0);
        add_item(dngs_pkg::OP_LOAD, 10'd2, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 0, 0, 0);
        add_item(dngs_pkg::OP_LOAD, 10'd3, ONE_Q824, 0, -ONE_Q824, 2 * ONE_Q824, 1, 0);
        add_item(dngs_pkg::OP_LOAD, 10'd1023, 32'h1234_5678, 32'hEDCB_A987, 0, '1, 0, 0);
        add_reg(dngs_pkg::CFG_BODY_COUNT, 32'd4);
        add_item(dngs_pkg::OP_EVAL, 10'd0, 0, 0, 0, 0, 0, 0);
        add_item(dngs_pkg::OP_EVAL, 10'd1, 0, 0, 0, 0, 0, 0);
        add_item(dngs_pkg::OP_EVAL, 10'd2, 0, 0, 0, 0, 0, 1);
        add_item(dngs_pkg::OP_EVAL, 10'd3, 0, 0, 0, 0, 0, 0);
        add_item(dngs_pkg::OP_EVAL, 10'd5, 0, 0, 0, 0, 0, 1);
        // coincident bodies with no softening
        add_reg(dngs_pkg::CFG_SOFTENING, 32'd0);
        add_item(dngs_pkg::OP_LOAD, 10'd4, 0, 0, 0, ONE_Q824, 1, 0);
        add_reg(dngs_pkg::CFG_BODY_COUNT, 32'd5);
        add_item(dngs_pkg::OP_EVAL, 10'd0, 0, 0, 0, 0, 0, 0);
        add_item(dngs_pkg::OP_EVAL, 10'd4, 0, 0, 0, 0, 0, 0);
        add_reg(dngs_pkg::CFG_SOFTENING, 32'hFFFF_FFFF);
        add_item(dngs_pkg::OP_EVAL, 10'd0, 0, 0, 0, 0, 0, 0);
        add_item(dngs_pkg::OP_EVAL, 10'd1, 0, 0, 0, 0, 0, 0);
        // counts at and above the store size, non-responding slots only
        add_reg(dngs_pkg::CFG_BODY_COUNT, 32'd2047);
        add_item(dngs_pkg::OP_EVAL, 10'd2, 0, 0, 0, 0, 0, 1);
        add_item(dngs_pkg::OP_EVAL, 10'd1023, 0, 0, 0, 0, 0, 1);
        add_reg(dngs_pkg::CFG_BODY_COUNT, 32'd1024);
        add_item(dngs_pkg::OP_EVAL, 10'd2, 0, 0, 0, 0, 0, 1);

        foreach (rows[k]) begin
            if (rows[k].kind == ROW_CFG) write_reg(rows[k].reg_index, rows[k].reg_data);
            else send_request(rows[k].op, rows[k].index, rows[k].px, rows[k].py,
                              rows[k].pz, rows[k].mass, rows[k].resp,
                              rows[k].known_zero);
        end

        done = 0;
        paused = 0;
        while (done < 555) begin
            case ($urandom_range(0, 4))
                0: soft_len = 0;
                1: soft_len = '1;
                2: soft_len = ONE_Q824;
                3: soft_len = $urandom;
                default: soft_len = $urandom_range(0, 32'h0400_0000);
            endcase
            write_reg(dngs_pkg::CFG_SOFTENING, soft_len);
            case ($urandom_range(0, 9))
                0: count = 0;
                1: count = 1;
                2: count = 8;
                default: count = $urandom_range(2, 6);
            endcase
            write_reg(dngs_pkg::CFG_BODY_COUNT, 32'(count));
            phase_len = $urandom_range(30, 70);
            for (int n = 0; n < phase_len && done < 555; n++) begin
                if (done > 480) quiet = 1;
                if (!paused && done >= 250) begin
                    // hold off until the engine has emptied
                    push <= 0;
                    do @(posedge i_clk); while (expected_sums.size() != 0);
                    paused = 1;
                end
                if ($urandom_range(0, 1)) begin
                    if ($urandom_range(0, 4) != 0) idx = 10'($urandom_range(0, count));
                    else idx = 10'($urandom);
                    if (idx < count && !sources_loaded(count)) begin
                        slot = 0;
                        while (loaded[slot]) slot++;
                        send_request(dngs_pkg::OP_LOAD, 10'(slot), rand_coord(),
                                     rand_coord(), rand_coord(), rand_mass(), 1, 0);
                    end else begin
                        send_request(dngs_pkg::OP_EVAL, idx, $urandom, $urandom,
                                     $urandom, $urandom, 1'($urandom_range(0, 1)), 0);
                    end
                end else begin
                    if ($urandom_range(0, 6) != 0) idx = 10'($urandom_range(0, count + 1));
                    else idx = 10'($urandom);
                    send_request(dngs_pkg::OP_LOAD, idx, rand_coord(), rand_coord(),
                                 rand_coord(), rand_mass(), $urandom_range(0, 6) != 0, 0);
                end
                done++;
            end
        end

        push <= 0;
        while (expected_sums.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("Covered %0d loads and %0d evaluates, %0d results compared (%0d saturated).",
                 n_loads, n_evals, n_checked, n_sat);
        $display("Softening from zero to full scale, source counts from none to above capacity.");
        if (errors == 0) begin
            $display("direct_nbody_gravity_sum_tb: PASS");
        end else begin
            $display("direct_nbody_gravity_sum_tb: FAIL");
        end
        $finish;
    end

endmodule
